// ===== design/fbt_pkg.sv =====
// fbt_pkg: shared types and constants for the flash unit busy timer.
// No dependencies; used by every module of the block except fbt_state_mem.
package fbt_pkg;

    localparam int TIME_W  = 20;
    localparam int TAG_W   = 16;
    localparam int UNIT_W  = 4;
    localparam int CLASS_W = 3;
    localparam int MAX_OUT = 16;
    localparam int CNT_W   = $clog2(MAX_OUT + 1);

    // t/10 as (t * RECIP) >> RECIP_SH, exact for t below 2**22
    localparam logic [TIME_W-1:0] RECIP    = TIME_W'(838861);
    localparam int                RECIP_SH = 23;

    localparam logic [CLASS_W-1:0] CLS_READ    = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_PROGRAM = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_ERASE   = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_DUMMY   = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_TRIM    = 3'd4;

    localparam logic OP_CMD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] REG_TIMING  = 2'd0;
    localparam logic [1:0] REG_READ    = 2'd1;
    localparam logic [1:0] REG_PROGRAM = 2'd2;
    localparam logic [1:0] REG_ERASE   = 2'd3;

    typedef enum logic [1:0] {
        KIND_PENDING = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_BUSY    = 2'd2,
        KIND_INVALID = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [UNIT_W-1:0]  unit;
        logic [TAG_W-1:0]   tag;
        logic               last;
    } res_t;

    // control from the sequencer to the result stage
    typedef struct packed {
        logic cmd_push;
        logic cpl_push;
        logic flush;
    } q_ctrl_t;

    typedef struct packed {
        logic out_free;
        logic pend_valid;
    } q_stat_t;

endpackage

// ===== design/fbt_state_mem.sv =====
// fbt_state_mem: per-unit countdown and tag storage, one write and one read port.
// Read data registered, held while no read is issued. Depends on nothing.
module fbt_state_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 36
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/fbt_result_q.sv =====
// fbt_result_q: output register plus a one-entry holding slot for tick completions,
// so the final completion of a scan can be flagged last. Depends on fbt_pkg.
module fbt_result_q (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  fbt_pkg::q_ctrl_t          ctrl,
    input  fbt_pkg::res_t             cmd_res,
    input  logic [fbt_pkg::UNIT_W-1:0] cpl_unit,
    input  logic [fbt_pkg::TAG_W-1:0]  cpl_tag,
    output fbt_pkg::q_stat_t          stat,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_kind,
    output logic [fbt_pkg::UNIT_W-1:0] m_done_unit,
    output logic [fbt_pkg::TAG_W-1:0]  m_done_tag,
    output logic                      m_last
);
    import fbt_pkg::*;

    logic               out_valid_reg, out_valid_next;
    res_t               out_reg, out_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [UNIT_W-1:0]  pend_unit_reg, pend_unit_next;
    logic [TAG_W-1:0]   pend_tag_reg, pend_tag_next;
    logic               out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_unit_next  = pend_unit_reg;
        pend_tag_next   = pend_tag_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        priority if (ctrl.cmd_push) begin
            out_valid_next = 1'b1;
            out_next       = cmd_res;
        end else if (ctrl.cpl_push) begin
            // a newer completion pushes the held one out, not last
            if (pend_valid_reg) begin
                out_valid_next = 1'b1;
                out_next       = '{kind: KIND_DONE, unit: pend_unit_reg,
                                   tag: pend_tag_reg, last: 1'b0};
            end
            pend_valid_next = 1'b1;
            pend_unit_next  = cpl_unit;
            pend_tag_next   = cpl_tag;
        end else if (ctrl.flush && pend_valid_reg) begin
            out_valid_next  = 1'b1;
            out_next        = '{kind: KIND_DONE, unit: pend_unit_reg,
                                tag: pend_tag_reg, last: 1'b1};
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg       <= out_next;
        pend_unit_reg <= pend_unit_next;
        pend_tag_reg  <= pend_tag_next;
    end

    assign stat.out_free   = out_free;
    assign stat.pend_valid = pend_valid_reg;

    assign m_valid     = out_valid_reg;
    assign m_kind      = out_reg.kind;
    assign m_done_unit = out_reg.unit;
    assign m_done_tag  = out_reg.tag;
    assign m_last      = out_reg.last;

endmodule

// ===== design/flash_unit_busy_timer.sv =====
// flash_unit_busy_timer: top level, sequencer, busy flags and configuration registers.
// Depends on fbt_pkg, fbt_state_mem and fbt_result_q.
//
// One item at a time. A command goes through busy-time select, the multiply for
// the tenth, then check and write-back, and waits there for the output register.
// A tick walks the state memory one unit per cycle through its single read port,
// except while the result channel stalls as completions are being handed out.
// Completions come in ascending unit order, at most 16 per tick; a unit past that
// cap stays busy and completes on the next tick. Configuration writes are taken
// every cycle and must only be issued while the block is idle. No clearing pass
// after reset.
module flash_unit_busy_timer #(
    parameter int NUM_UNITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_operation,
    input  logic [fbt_pkg::CLASS_W-1:0] s_req_class,
    input  logic [fbt_pkg::UNIT_W-1:0]  s_unit_id,
    input  logic [fbt_pkg::TAG_W-1:0]   s_request_tag,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_kind,
    output logic [fbt_pkg::UNIT_W-1:0]  m_done_unit,
    output logic [fbt_pkg::TAG_W-1:0]   m_done_tag,
    output logic                        m_last,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [fbt_pkg::TIME_W-1:0]  cfg_data
);
    import fbt_pkg::*;

    localparam int AW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
    localparam int DW = TIME_W + TAG_W;
    localparam int QW = 2 * TIME_W - RECIP_SH;
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_UNITS - 1);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_CMD_MUL  = 5'b00010,
        ST_CMD_DONE = 5'b00100,
        ST_SCAN     = 5'b01000,
        ST_SCAN_END = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [NUM_UNITS-1:0]   busy_reg, busy_next;
    logic [AW-1:0]          scan_reg, scan_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CLASS_W-1:0]     cls_reg, cls_next;
    logic [UNIT_W-1:0]      unit_reg, unit_next;
    logic [TAG_W-1:0]       tag_reg, tag_next;
    logic [TIME_W-1:0]      time_reg, time_next;
    logic [QW-1:0]          quot_reg, quot_next;

    logic                   timing_en_reg;
    logic [TIME_W-1:0]      read_time_reg, program_time_reg, erase_time_reg;

    logic                   mem_we, rd_en;
    logic [AW-1:0]          wr_addr, rd_addr;
    logic [DW-1:0]          wr_data, rd_data;
    logic [TIME_W-1:0]      rd_rem, dec_rem, sel_time;
    logic [TAG_W-1:0]       rd_tag;
    logic [2*TIME_W-1:0]    prod;

    q_ctrl_t                q_ctrl;
    q_stat_t                q_stat;
    res_t                   cmd_res;
    logic [UNIT_W-1:0]      cpl_unit;

    logic                   s_fire, cur_busy, complete, stall;
    logic                   bad_cmd, in_range;
    logic [AW-1:0]          cmd_idx;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timing_en_reg    <= 1'b0;
            read_time_reg    <= '0;
            program_time_reg <= '0;
            erase_time_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TIMING:  timing_en_reg    <= cfg_data[0];
                REG_READ:    read_time_reg    <= cfg_data;
                REG_PROGRAM: program_time_reg <= cfg_data;
                REG_ERASE:   erase_time_reg   <= cfg_data;
                default:     timing_en_reg    <= timing_en_reg;
            endcase
        end
    end

    always_comb begin
        priority if (s_req_class == CLS_READ) begin
            sel_time = read_time_reg;
        end else if (s_req_class == CLS_PROGRAM) begin
            sel_time = program_time_reg;
        end else if (s_req_class == CLS_ERASE) begin
            sel_time = erase_time_reg;
        end else begin
            sel_time = '0;
        end
    end

    assign prod   = {{TIME_W{1'b0}}, time_reg} * {{TIME_W{1'b0}}, RECIP};
    assign rd_rem = rd_data[DW-1:TAG_W];
    assign rd_tag = rd_data[TAG_W-1:0];

    assign in_range = (32'(unit_reg) < NUM_UNITS);
    assign cmd_idx  = AW'(unit_reg);
    assign bad_cmd  = (cls_reg > CLS_TRIM) || ((cls_reg == CLS_TRIM) && timing_en_reg)
                      || !in_range;

    assign cur_busy = busy_reg[scan_reg];
    assign dec_rem  = (rd_rem != '0) ? rd_rem - TIME_W'(1) : '0;
    assign complete = cur_busy && (dec_rem == '0) && (32'(cnt_reg) < MAX_OUT);
    // a new completion must push the held one out, which needs the output free
    assign stall    = complete && q_stat.pend_valid && !q_stat.out_free;
    assign cpl_unit = UNIT_W'(scan_reg);

    always_comb begin
        state_next = state_reg;
        busy_next  = busy_reg;
        scan_next  = scan_reg;
        cnt_next   = cnt_reg;
        cls_next   = cls_reg;
        unit_next  = unit_reg;
        tag_next   = tag_reg;
        time_next  = time_reg;
        quot_next  = quot_reg;
        mem_we     = 1'b0;
        wr_addr    = scan_reg;
        wr_data    = {dec_rem, rd_tag};
        rd_en      = 1'b0;
        rd_addr    = '0;
        q_ctrl     = '0;
        cmd_res    = '{kind: KIND_DONE, unit: unit_reg, tag: tag_reg, last: 1'b1};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_operation == OP_TICK) begin
                        rd_en      = 1'b1;
                        scan_next  = '0;
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end else begin
                        cls_next   = s_req_class;
                        unit_next  = s_unit_id;
                        tag_next   = s_request_tag;
                        time_next  = sel_time;
                        state_next = ST_CMD_MUL;
                    end
                end
            end
            ST_CMD_MUL: begin
                quot_next  = prod[2*TIME_W-1:RECIP_SH];
                state_next = ST_CMD_DONE;
            end
            ST_CMD_DONE: begin
                priority if (bad_cmd) begin
                    cmd_res.kind = KIND_INVALID;
                end else if (busy_reg[cmd_idx]) begin
                    cmd_res.kind = KIND_BUSY;
                end else if (!timing_en_reg) begin
                    cmd_res.kind = KIND_DONE;
                end else begin
                    cmd_res.kind = KIND_PENDING;
                end
                if (q_stat.out_free) begin
                    q_ctrl.cmd_push = 1'b1;
                    if (cmd_res.kind == KIND_PENDING) begin
                        mem_we             = 1'b1;
                        wr_addr            = cmd_idx;
                        wr_data            = {time_reg - TIME_W'(quot_reg), tag_reg};
                        busy_next[cmd_idx] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    if (cur_busy) begin
                        mem_we = 1'b1;
                    end
                    if (complete) begin
                        busy_next[scan_reg] = 1'b0;
                        q_ctrl.cpl_push     = 1'b1;
                        cnt_next            = cnt_reg + CNT_W'(1);
                    end
                    if (scan_reg == LAST_IDX) begin
                        state_next = ST_SCAN_END;
                    end else begin
                        rd_en     = 1'b1;
                        rd_addr   = scan_reg + AW'(1);
                        scan_next = scan_reg + AW'(1);
                    end
                end
            end
            ST_SCAN_END: begin
                if (!q_stat.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (q_stat.out_free) begin
                    q_ctrl.flush = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            busy_reg  <= '0;
            scan_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            scan_reg  <= scan_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        cls_reg  <= cls_next;
        unit_reg <= unit_next;
        tag_reg  <= tag_next;
        time_reg <= time_next;
        quot_reg <= quot_next;
    end

    fbt_state_mem #(
        .DEPTH (NUM_UNITS),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .aclk    (aclk),
        .we      (mem_we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fbt_result_q u_resq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (q_ctrl),
        .cmd_res     (cmd_res),
        .cpl_unit    (cpl_unit),
        .cpl_tag     (rd_tag),
        .stat        (q_stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_done_unit (m_done_unit),
        .m_done_tag  (m_done_tag),
        .m_last      (m_last)
    );

    // held completion never survives the end of a scan
    a_pend_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !q_stat.pend_valid)
        else $error("held completion left over in idle");

    // write-back and next read never hit the same entry
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && rd_en) |-> (wr_addr != rd_addr))
        else $error("state memory read and write to same entry");

    // result stage is only loaded when its output register can take a beat
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_ctrl.cmd_push || (q_ctrl.cpl_push && q_stat.pend_valid) || q_ctrl.flush)
        |-> q_stat.out_free)
        else $error("result pushed into a full output register");

    // busy flags change only while an item is being worked
    a_busy_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |=> (busy_reg == $past(busy_reg)))
        else $error("busy flags changed while idle");

endmodule

// ===== tb/fbt_checker.sv =====
// fbt_checker: watches the command, result and register channels of the busy timer,
// predicts every result beat and compares it field by field in arrival order.
// Depends on fbt_pkg.
module fbt_checker #(
    parameter int NUM_UNITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic                         s_operation,
    input  logic [fbt_pkg::CLASS_W-1:0]  s_req_class,
    input  logic [fbt_pkg::UNIT_W-1:0]   s_unit_id,
    input  logic [fbt_pkg::TAG_W-1:0]    s_request_tag,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [1:0]                   m_kind,
    input  logic [fbt_pkg::UNIT_W-1:0]   m_done_unit,
    input  logic [fbt_pkg::TAG_W-1:0]    m_done_tag,
    input  logic                         m_last,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [fbt_pkg::TIME_W-1:0]   cfg_data,
    output int unsigned                  mismatches,
    output int unsigned                  outstanding
);
    import fbt_pkg::*;

    logic              timing_on;
    logic [TIME_W-1:0] t_read;
    logic [TIME_W-1:0] t_program;
    logic [TIME_W-1:0] t_erase;

    logic              unit_busy [NUM_UNITS];
    logic [TIME_W-1:0] unit_left [NUM_UNITS];
    logic [TAG_W-1:0]  unit_tag  [NUM_UNITS];

    res_t awaited_res [$];

    function automatic logic [TIME_W-1:0] busy_countdown(logic [CLASS_W-1:0] cls);
        logic [TIME_W-1:0] t;
        case (cls)
            CLS_READ:    t = t_read;
            CLS_PROGRAM: t = t_program;
            CLS_ERASE:   t = t_erase;
            default:     t = '0;
        endcase
        return t - TIME_W'(t / 10);
    endfunction

    task automatic expect_one(kind_t kind, logic [UNIT_W-1:0] unit, logic [TAG_W-1:0] tag,
                              logic last);
        res_t r;
        r.kind = kind;
        r.unit = unit;
        r.tag  = tag;
        r.last = last;
        awaited_res.push_back(r);
    endtask

    // one microsecond: count every busy unit down, release the ones reaching zero
    task automatic emulate_tick();
        int                n;
        logic              have_held;
        logic [UNIT_W-1:0] held_unit;
        logic [TAG_W-1:0]  held_tag;
        n = 0;
        have_held = 1'b0;
        held_unit = '0;
        held_tag = '0;
        for (int u = 0; u < NUM_UNITS; u++) begin
            if (!unit_busy[u]) continue;
            if (unit_left[u] != 0) unit_left[u]--;
            if (unit_left[u] == 0 && n < MAX_OUT) begin
                unit_busy[u] = 1'b0;
                if (have_held) expect_one(KIND_DONE, held_unit, held_tag, 1'b0);
                have_held = 1'b1;
                held_unit = UNIT_W'(u);
                held_tag = unit_tag[u];
                n++;
            end
        end
        if (have_held) expect_one(KIND_DONE, held_unit, held_tag, 1'b1);
    endtask

    task automatic emulate_command(logic [CLASS_W-1:0] cls, logic [UNIT_W-1:0] unit,
                                   logic [TAG_W-1:0] tag);
        // class first, then unit range, then busy
        if (cls > CLS_TRIM || (cls == CLS_TRIM && timing_on) || int'(unit) >= NUM_UNITS) begin
            expect_one(KIND_INVALID, unit, tag, 1'b1);
        end else if (unit_busy[unit]) begin
            expect_one(KIND_BUSY, unit, tag, 1'b1);
        end else if (!timing_on) begin
            expect_one(KIND_DONE, unit, tag, 1'b1);
        end else begin
            unit_busy[unit] = 1'b1;
            unit_tag[unit] = tag;
            unit_left[unit] = busy_countdown(cls);
            expect_one(KIND_PENDING, unit, tag, 1'b1);
        end
    endtask

    task automatic check_result();
        res_t want;
        if (awaited_res.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result kind=%0d unit=%0d tag=%h last=%0b", $time,
                     m_kind, m_done_unit, m_done_tag, m_last);
            return;
        end
        want = awaited_res.pop_front();
        if (m_kind != want.kind || m_done_unit != want.unit || m_done_tag != want.tag
                || m_last != want.last) begin
            mismatches++;
            $display("%0t: kind/unit/tag/last expected %0d/%0d/%h/%0b got %0d/%0d/%h/%0b",
                     $time, want.kind, want.unit, want.tag, want.last,
                     m_kind, m_done_unit, m_done_tag, m_last);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            timing_on = 1'b0;
            t_read = '0;
            t_program = '0;
            t_erase = '0;
            for (int u = 0; u < NUM_UNITS; u++) begin
                unit_busy[u] = 1'b0;
                unit_left[u] = '0;
                unit_tag[u] = '0;
            end
            awaited_res.delete();
            mismatches = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TIMING:  timing_on = cfg_data[0];
                    REG_READ:    t_read = cfg_data;
                    REG_PROGRAM: t_program = cfg_data;
                    REG_ERASE:   t_erase = cfg_data;
                    default:     ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_operation == OP_TICK) emulate_tick();
                else emulate_command(s_req_class, s_unit_id, s_request_tag);
            end
            if (m_valid && m_ready) check_result();
        end
        outstanding = awaited_res.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: stimulus and verdict for flash_unit_busy_timer; directed commands and ticks,
// then randomized phases under several register settings. Depends on fbt_pkg and fbt_checker.
module tb_top;
    import fbt_pkg::*;

    localparam int NUM_UNITS     = 16;
    localparam int CLK_PERIOD    = 8;
    localparam int SETTLE_CYCLES = 4 * (NUM_UNITS + 2);
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;

    localparam logic [CLASS_W-1:0] CLS_BAD_FIRST = CLS_TRIM + 3'd1;
    localparam logic [CLASS_W-1:0] CLS_BAD_LAST  = 3'd7;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic                s_operation   = OP_CMD;
    logic [CLASS_W-1:0]  s_req_class   = '0;
    logic [UNIT_W-1:0]   s_unit_id     = '0;
    logic [TAG_W-1:0]    s_request_tag = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [1:0]          m_kind;
    logic [UNIT_W-1:0]   m_done_unit;
    logic [TAG_W-1:0]    m_done_tag;
    logic                m_last;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index     = REG_TIMING;
    logic [TIME_W-1:0]   cfg_data      = '0;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned quiet_cycles  = 0;
    int          hold_requests = 0;
    int          burst_left    = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    flash_unit_busy_timer #(
        .NUM_UNITS(NUM_UNITS)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_operation(s_operation),
        .s_req_class(s_req_class),
        .s_unit_id(s_unit_id),
        .s_request_tag(s_request_tag),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_kind(m_kind),
        .m_done_unit(m_done_unit),
        .m_done_tag(m_done_tag),
        .m_last(m_last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    fbt_checker #(
        .NUM_UNITS(NUM_UNITS)
    ) i_checker (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_operation(s_operation),
        .s_req_class(s_req_class),
        .s_unit_id(s_unit_id),
        .s_request_tag(s_request_tag),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_kind(m_kind),
        .m_done_unit(m_done_unit),
        .m_done_tag(m_done_tag),
        .m_last(m_last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatches(mismatches),
        .outstanding(outstanding)
    );

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic offer(logic op, logic [CLASS_W-1:0] cls, logic [UNIT_W-1:0] unit,
                         logic [TAG_W-1:0] tag);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(8, 0);
            if (gap != 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(24, 1);
        end
        burst_left--;
        s_valid = 1'b1;
        s_operation = op;
        s_req_class = cls;
        s_unit_id = unit;
        s_request_tag = tag;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic offer_tick();
        offer(OP_TICK, CLASS_W'($urandom), UNIT_W'($urandom), TAG_W'($urandom));
    endtask

    task automatic offer_random();
        int unsigned pick;
        logic [CLASS_W-1:0] cls;
        pick = $urandom_range(99, 0);
        if (pick < 35) begin
            offer_tick();
        end else begin
            pick = $urandom_range(99, 0);
            if (pick < 80) cls = CLASS_W'($urandom_range(CLS_DUMMY, CLS_READ));
            else if (pick < 88) cls = CLS_TRIM;
            else cls = CLASS_W'($urandom_range(CLS_BAD_LAST, CLS_BAD_FIRST));
            offer(OP_CMD, cls, UNIT_W'($urandom), TAG_W'($urandom));
        end
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    // a tick with no completion leaves no trace, so give the scan time to finish
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [TIME_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic reconfigure(logic on, logic [TIME_W-1:0] t_rd, logic [TIME_W-1:0] t_pg,
                               logic [TIME_W-1:0] t_er);
        settle();
        write_reg(REG_TIMING, TIME_W'(on));
        write_reg(REG_READ, t_rd);
        write_reg(REG_PROGRAM, t_pg);
        write_reg(REG_ERASE, t_er);
    endtask

    task automatic run_random(int count, int hold_at, int pause_at);
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) hold_requests++;
            if (i == pause_at) drain();
            offer_random();
        end
    endtask

    // result side: stall density changes between random-length modes, plus requested hold-offs
    initial begin : receiver
        int stall_pct;
        int mode_left;
        int holds_done;
        stall_pct = 0;
        mode_left = 0;
        holds_done = 0;
        forever begin
            @(negedge aclk);
            if (holds_done != hold_requests) begin
                holds_done++;
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(64, 8);
                stall_pct = 25 * $urandom_range(3, 0);
            end
            mode_left--;
            m_ready = (int'($urandom_range(99, 0)) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // timing off after reset: valid classes incl. trim complete at once
        offer(OP_CMD, CLS_READ, 4'd0, 16'h0000);
        offer(OP_CMD, CLS_PROGRAM, 4'd15, 16'hffff);
        offer(OP_CMD, CLS_ERASE, 4'd7, 16'h1234);
        offer(OP_CMD, CLS_DUMMY, 4'd8, 16'habcd);
        offer(OP_CMD, CLS_TRIM, 4'd3, 16'h5555);
        for (int c = CLS_BAD_FIRST; c <= CLS_BAD_LAST; c++)
            offer(OP_CMD, CLASS_W'(c), UNIT_W'($urandom), TAG_W'($urandom));
        offer_tick();

        // timing on: zero countdown, short program, erase still busy later
        reconfigure(1'b1, 20'd0, 20'd1, 20'd5);
        offer(OP_CMD, CLS_READ, 4'd0, 16'hffff);
        offer(OP_CMD, CLS_PROGRAM, 4'd1, 16'h0001);
        offer(OP_CMD, CLS_ERASE, 4'd15, 16'h8000);
        offer(OP_CMD, CLS_DUMMY, 4'd3, 16'h7fff);
        offer(OP_CMD, CLS_TRIM, 4'd4, 16'h0f0f);
        offer(OP_CMD, CLS_READ, 4'd0, 16'h00ff);
        offer(OP_CMD, CLS_BAD_LAST, 4'd0, 16'hf0f0);
        offer_tick();
        offer_tick();

        // timing off with the erase unit still counting down
        settle();
        write_reg(REG_TIMING, TIME_W'(1'b0));
        offer(OP_CMD, CLS_READ, 4'd15, 16'h2222);
        offer(OP_CMD, CLS_TRIM, 4'd15, 16'h3333);
        repeat (3) offer_tick();

        reconfigure(1'b1, 20'd5, 20'd12, 20'd25);
        run_random(85, 30, -1);

        reconfigure(1'b0, TIME_W'($urandom_range(40, 0)), TIME_W'($urandom_range(40, 0)),
                    TIME_W'($urandom_range(40, 0)));
        run_random(70, -1, -1);

        reconfigure(1'b1, 20'd1, 20'd0, 20'd3);
        run_random(85, -1, 40);

        reconfigure(1'b1, TIME_W'($urandom_range(40, 0)), TIME_W'($urandom_range(40, 0)),
                    TIME_W'($urandom_range(40, 0)));
        run_random(85, -1, -1);

        // longest busy times: units taken here stay busy for the rest of the run
        reconfigure(1'b1, '1, '1, '1);
        run_random(30, -1, -1);

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
